/* design/ilha_pkg.sv */
// Shared types and constants for the implicit-list heap allocator.
// Used by the channel interfaces, the header walker and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ilha_pkg;

  // Arena geometry.
  localparam int ARENA_BYTES   = 4096;
  localparam int GRANULE_BYTES = 8;
  localparam int GRANULES      = ARENA_BYTES / GRANULE_BYTES;
  localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
  localparam int GIDX_W        = $clog2(GRANULES);
  localparam int SIZE_W        = GIDX_W + 1;

  // Field widths of the channels.
  localparam int REQ_W   = 12;
  localparam int OFF_W   = 12;
  localparam int STYLE_W = 2;
  localparam int STAT_W  = 2;

  // Request size in granules including the header, and a freed block's index.
  localparam int NEED_W = REQ_W - GRAN_SHIFT + 1;
  localparam int TGT_W  = OFF_W - GRAN_SHIFT;
  localparam int CNT_W  = (SIZE_W > NEED_W) ? SIZE_W : NEED_W;

  // Highest block start whose payload offset still fits in OFF_W bits.
  localparam int OFFSET_MAX = (1 << OFF_W) - 1;
  localparam int POS_MAX    = OFFSET_MAX / GRANULE_BYTES - 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STYLE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_ARG  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    W_INIT,
    W_IDLE,
    W_WALK,
    W_AFIN,
    W_AWR,
    W_FSUCC,
    W_FWR1,
    W_FWR2,
    W_DONE
  } wstate_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic               opcode;
    logic [REQ_W-1:0]   request_bytes;
    logic [STYLE_W-1:0] fit_style;
    logic [OFF_W-1:0]   release_offset;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  payload_offset;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [GIDX_W-1:0] addr;
    hdr_t              wdata;
  } mem_req_t;

endpackage

`default_nettype wire

/* design/ilha_req_if.sv */
// Request channel of the heap allocator: valid/ready plus the request fields.
// Depends on ilha_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ilha_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [ilha_pkg::REQ_W-1:0]   request_bytes;
  logic [ilha_pkg::STYLE_W-1:0] fit_style;
  logic [ilha_pkg::OFF_W-1:0]   release_offset;

  modport source (
    output valid, opcode, request_bytes, fit_style, release_offset,
    input  ready
  );
  modport sink (
    input  valid, opcode, request_bytes, fit_style, release_offset,
    output ready
  );
endinterface

`default_nettype wire

/* design/ilha_rsp_if.sv */
// Response channel of the heap allocator: valid/ready plus status and offset.
// Depends on ilha_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ilha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ilha_pkg::STAT_W-1:0] status;
  logic [ilha_pkg::OFF_W-1:0]  payload_offset;

  modport source (
    output valid, status, payload_offset,
    input  ready
  );
  modport sink (
    input  valid, status, payload_offset,
    output ready
  );
endinterface

`default_nettype wire

/* design/implicit_list_heap_allocator_unit.sv */
// Top level of the implicit-list heap allocator: header RAM, header walker
// and the response output register. Depends on ilha_pkg and the channel interfaces.
//
//   Channel   Role    Transaction
//   request   sink    opcode, request_bytes, fit_style, release_offset
//   response  source  status, payload_offset
//
// One request is handled at a time: the walker visits the block headers in turn,
// then writes back any split or merged headers and offers the response.
// The walk rate is set by the single header RAM port: one header read per cycle.
// After reset the block writes the first header before it takes a request.
// The response sits in an output register, so the next request
// is taken while a response still waits; a stalled response stalls the walker
// only when its next response is ready.
`timescale 1ns / 1ps
`default_nettype none

module implicit_list_heap_allocator_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  ilha_req_if.sink   request,
  ilha_rsp_if.source response
);

  ilha_pkg::cmd_t                        cmd;
  ilha_pkg::rsp_t                        res;
  ilha_pkg::mem_req_t                    mem_req;
  logic [$bits(ilha_pkg::hdr_t)-1:0]     mem_rdata;
  logic                                  idle;
  logic                                  start;
  logic                                  res_valid;
  logic                                  res_ready;

  assign cmd.opcode         = request.opcode;
  assign cmd.request_bytes  = request.request_bytes;
  assign cmd.fit_style      = request.fit_style;
  assign cmd.release_offset = request.release_offset;

  assign request.ready = idle;
  assign start         = request.valid && idle;
  assign res_ready     = !response.valid || response.ready;

  ilha_hdr_ram #(
    .DEPTH (ilha_pkg::GRANULES),
    .WIDTH ($bits(ilha_pkg::hdr_t))
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  ilha_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      response.status         <= res.status;
      response.payload_offset <= res.payload_offset;
    end
  end

endmodule

`default_nettype wire

/* design/ilha_hdr_ram.sv */
// Single-port synchronous RAM holding one block header per granule.
// Registered read data, one access per cycle; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ilha_hdr_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 11
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* design/ilha_walker.sv */
// Header walker: sequencer that walks the block chain in the header RAM,
// picks or locates a block, and writes back split or merged headers.
// Depends on ilha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilha_walker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire ilha_pkg::cmd_t                   cmd,
  output logic                                  idle,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output ilha_pkg::rsp_t                        res,
  output ilha_pkg::mem_req_t                    mem_req,
  input  wire logic [$bits(ilha_pkg::hdr_t)-1:0] mem_rdata
);

  ilha_pkg::wstate_t state, state_next;

  logic                            op, op_next;
  logic [ilha_pkg::NEED_W-1:0]     need, need_next;
  logic [ilha_pkg::STYLE_W-1:0]    style, style_next;
  logic [ilha_pkg::TGT_W-1:0]      target, target_next;
  logic [ilha_pkg::GIDX_W-1:0]     pos, pos_next;
  logic                            found, found_next;
  logic [ilha_pkg::GIDX_W-1:0]     pick, pick_next;
  logic [ilha_pkg::SIZE_W-1:0]     pick_sz, pick_sz_next;
  logic [ilha_pkg::GIDX_W-1:0]     prev, prev_next;
  ilha_pkg::hdr_t                  prev_hdr, prev_hdr_next;
  logic                            have_prev, have_prev_next;
  logic [ilha_pkg::SIZE_W-1:0]     tsz, tsz_next;
  logic [ilha_pkg::STAT_W-1:0]     res_status, res_status_next;
  logic [ilha_pkg::OFF_W-1:0]      res_offset, res_offset_next;

  ilha_pkg::hdr_t                  hdr;
  logic [ilha_pkg::CNT_W-1:0]      nxt;
  logic [ilha_pkg::REQ_W:0]        req_round;
  logic                            fits;
  logic                            better;
  logic                            at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilha_pkg::W_INIT;
    end else begin
      state <= state_next;
    end
    op         <= op_next;
    need       <= need_next;
    style      <= style_next;
    target     <= target_next;
    pos        <= pos_next;
    found      <= found_next;
    pick       <= pick_next;
    pick_sz    <= pick_sz_next;
    prev       <= prev_next;
    prev_hdr   <= prev_hdr_next;
    have_prev  <= have_prev_next;
    tsz        <= tsz_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
  end

  always_comb begin
    hdr       = ilha_pkg::hdr_t'(mem_rdata);
    nxt       = ilha_pkg::CNT_W'(pos) + ilha_pkg::CNT_W'(hdr.size);
    at_end    = nxt >= ilha_pkg::CNT_W'(ilha_pkg::GRANULES);
    req_round = {1'b0, cmd.request_bytes} + (ilha_pkg::REQ_W + 1)'(ilha_pkg::GRANULE_BYTES - 1);
    fits      = hdr.free
                && (ilha_pkg::CNT_W'(hdr.size) >= ilha_pkg::CNT_W'(need))
                && (ilha_pkg::CNT_W'(pos) <= ilha_pkg::CNT_W'(ilha_pkg::POS_MAX));
    better    = !found
                || (style == ilha_pkg::FIT_BEST && hdr.size < pick_sz)
                || (style == ilha_pkg::FIT_WORST && hdr.size > pick_sz);

    state_next      = state;
    op_next         = op;
    need_next       = need;
    style_next      = style;
    target_next     = target;
    pos_next        = pos;
    found_next      = found;
    pick_next       = pick;
    pick_sz_next    = pick_sz;
    prev_next       = prev;
    prev_hdr_next   = prev_hdr;
    have_prev_next  = have_prev;
    tsz_next        = tsz;
    res_status_next = res_status;
    res_offset_next = res_offset;
    mem_req         = '0;
    idle            = 1'b0;
    res_valid       = 1'b0;

    case (state)
      ilha_pkg::W_INIT: begin
        // Header 0 describes one free block over the whole arena.
        mem_req.we         = 1'b1;
        mem_req.addr       = '0;
        mem_req.wdata.free = 1'b1;
        mem_req.wdata.size = ilha_pkg::SIZE_W'(ilha_pkg::GRANULES);
        state_next         = ilha_pkg::W_IDLE;
      end

      ilha_pkg::W_IDLE: begin
        idle = 1'b1;
        if (start) begin
          op_next         = cmd.opcode;
          need_next       = ilha_pkg::NEED_W'(req_round[ilha_pkg::REQ_W:ilha_pkg::GRAN_SHIFT])
                            + ilha_pkg::NEED_W'(1);
          style_next      = cmd.fit_style;
          target_next     = cmd.release_offset[ilha_pkg::OFF_W-1:ilha_pkg::GRAN_SHIFT]
                            - ilha_pkg::TGT_W'(1);
          pos_next        = '0;
          found_next      = 1'b0;
          have_prev_next  = 1'b0;
          res_offset_next = '0;
          res_status_next = ilha_pkg::ST_OK;
          if (cmd.opcode == ilha_pkg::OP_ALLOC) begin
            if (cmd.fit_style != ilha_pkg::FIT_FIRST && cmd.fit_style != ilha_pkg::FIT_BEST
                && cmd.fit_style != ilha_pkg::FIT_WORST) begin
              res_status_next = ilha_pkg::ST_NO_SPACE;
              state_next      = ilha_pkg::W_DONE;
            end else begin
              mem_req.re = 1'b1;
              state_next = ilha_pkg::W_WALK;
            end
          end else if (cmd.release_offset == '0
                       || cmd.release_offset[ilha_pkg::GRAN_SHIFT-1:0] != '0) begin
            res_status_next = ilha_pkg::ST_BAD_ARG;
            state_next      = ilha_pkg::W_DONE;
          end else begin
            mem_req.re = 1'b1;
            state_next = ilha_pkg::W_WALK;
          end
        end
      end

      ilha_pkg::W_WALK: begin
        // The read data holds the header at pos; the next header address
        // goes straight back to the RAM, so one block is visited per cycle.
        if (op == ilha_pkg::OP_ALLOC) begin
          if (fits && better) begin
            pick_next    = pos;
            pick_sz_next = hdr.size;
            found_next   = 1'b1;
          end
          if ((fits && style == ilha_pkg::FIT_FIRST) || at_end) begin
            state_next = ilha_pkg::W_AFIN;
          end else begin
            mem_req.re   = 1'b1;
            mem_req.addr = nxt[ilha_pkg::GIDX_W-1:0];
            pos_next     = nxt[ilha_pkg::GIDX_W-1:0];
          end
        end else if (ilha_pkg::CNT_W'(pos) == ilha_pkg::CNT_W'(target)) begin
          if (hdr.free) begin
            res_status_next = ilha_pkg::ST_BAD_ARG;
            state_next      = ilha_pkg::W_DONE;
          end else begin
            tsz_next = hdr.size;
            if (at_end) begin
              state_next = ilha_pkg::W_FWR1;
            end else begin
              mem_req.re   = 1'b1;
              mem_req.addr = nxt[ilha_pkg::GIDX_W-1:0];
              state_next   = ilha_pkg::W_FSUCC;
            end
          end
        end else if (ilha_pkg::CNT_W'(pos) > ilha_pkg::CNT_W'(target) || at_end) begin
          res_status_next = ilha_pkg::ST_BAD_ARG;
          state_next      = ilha_pkg::W_DONE;
        end else begin
          prev_next      = pos;
          prev_hdr_next  = hdr;
          have_prev_next = 1'b1;
          mem_req.re     = 1'b1;
          mem_req.addr   = nxt[ilha_pkg::GIDX_W-1:0];
          pos_next       = nxt[ilha_pkg::GIDX_W-1:0];
        end
      end

      ilha_pkg::W_AFIN: begin
        if (!found) begin
          res_status_next = ilha_pkg::ST_NO_SPACE;
          state_next      = ilha_pkg::W_DONE;
        end else begin
          // Split the remainder off as a new free block.
          if (ilha_pkg::CNT_W'(pick_sz) > ilha_pkg::CNT_W'(need)) begin
            mem_req.we         = 1'b1;
            mem_req.addr       = ilha_pkg::GIDX_W'(ilha_pkg::CNT_W'(pick)
                                                   + ilha_pkg::CNT_W'(need));
            mem_req.wdata.free = 1'b1;
            mem_req.wdata.size = pick_sz - ilha_pkg::SIZE_W'(need);
          end
          state_next = ilha_pkg::W_AWR;
        end
      end

      ilha_pkg::W_AWR: begin
        mem_req.we         = 1'b1;
        mem_req.addr       = pick;
        mem_req.wdata.free = 1'b0;
        mem_req.wdata.size = ilha_pkg::SIZE_W'(need);
        res_status_next    = ilha_pkg::ST_OK;
        res_offset_next    = ilha_pkg::OFF_W'({ilha_pkg::CNT_W'(pick) + ilha_pkg::CNT_W'(1),
                                               {ilha_pkg::GRAN_SHIFT{1'b0}}});
        state_next         = ilha_pkg::W_DONE;
      end

      ilha_pkg::W_FSUCC: begin
        if (hdr.free) begin
          tsz_next = tsz + hdr.size;
        end
        state_next = ilha_pkg::W_FWR1;
      end

      ilha_pkg::W_FWR1: begin
        mem_req.we         = 1'b1;
        mem_req.addr       = ilha_pkg::GIDX_W'(target);
        mem_req.wdata.free = 1'b1;
        mem_req.wdata.size = tsz;
        if (have_prev && prev_hdr.free) begin
          state_next = ilha_pkg::W_FWR2;
        end else begin
          res_status_next = ilha_pkg::ST_OK;
          state_next      = ilha_pkg::W_DONE;
        end
      end

      ilha_pkg::W_FWR2: begin
        mem_req.we         = 1'b1;
        mem_req.addr       = prev;
        mem_req.wdata.free = 1'b1;
        mem_req.wdata.size = prev_hdr.size + tsz;
        res_status_next    = ilha_pkg::ST_OK;
        state_next         = ilha_pkg::W_DONE;
      end

      ilha_pkg::W_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ilha_pkg::W_IDLE;
        end
      end

      default: begin
        state_next = ilha_pkg::W_IDLE;
      end
    endcase

    res.status         = res_status;
    res.payload_offset = res_offset;
  end

  // The single RAM port never sees a read and a write together.
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("header RAM read and write in one cycle");

  // Headers are only written in the write-back states or during init.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == ilha_pkg::W_INIT || state == ilha_pkg::W_AFIN
                    || state == ilha_pkg::W_AWR || state == ilha_pkg::W_FWR1
                    || state == ilha_pkg::W_FWR2))
    else $error("header write outside write-back");

  // A failed transaction never returns an offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ilha_pkg::ST_OK) |-> res.payload_offset == '0)
    else $error("nonzero offset on failure");

  // A successful allocation returns a granule-aligned, nonzero offset.
  a_alloc_offset: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ilha_pkg::ST_OK && op == ilha_pkg::OP_ALLOC)
      |-> (res.payload_offset != '0
           && res.payload_offset[ilha_pkg::GRAN_SHIFT-1:0] == '0))
    else $error("bad allocation offset");

  // A result stays on offer until it is taken.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result dropped before it was taken");

endmodule

`default_nettype wire
